/* rtl/nccg_pkg.sv */
package nccg_pkg;

  localparam int unsigned NCCG_QUEUE_DEPTH = 2;

  localparam logic [7:0] CMD_READ0       = 8'h00;
  localparam logic [7:0] CMD_READSTART   = 8'h30;
  localparam logic [7:0] CMD_READOOB     = 8'h50;
  localparam logic [7:0] CMD_READ_STATUS = 8'h70;
  localparam logic [7:0] CMD_RESET       = 8'hFF;

  localparam logic [1:0] CFG_PAGE_DATA_BYTES  = 2'd0;
  localparam logic [1:0] CFG_BUS_IS_16_BIT    = 2'd1;
  localparam logic [1:0] CFG_THREE_ROW_CYCLES = 2'd2;

  typedef struct packed {
    logic [7:0]  opcode;
    logic [15:0] column_address;
    logic        column_present;
    logic [23:0] row_address;
    logic        row_present;
  } in_word_t;

  typedef struct packed {
    logic [7:0] bus_byte;
    logic       byte_driven;
    logic       chip_enable;
    logic       command_latch;
    logic       address_latch;
    logic       lines_changed;
    logic       last_cycle;
  } out_word_t;

  // One classified request, ready for the cycle sequencer
  typedef struct packed {
    logic [7:0]  cmd;
    logic [15:0] col;
    logic        col_on;
    logic [23:0] row;
    logic        row_on;
    logic        three_rows;
    logic        tail_on;
    logic [7:0]  tail_cmd;
  } req_t;

endpackage

/* rtl/nand_command_cycle_generator.sv */
// An accepted request is written into the request queue before its first bus word is registered.
// Throughput: one bus word per cycle while out_stall is low; a request emits 2 to 9 words,
// issued by the output register of the cycle sequencer. Requests flow back to back.
// The request queue holds QueueDepth requests between classifier and sequencer.
// Reset (rst_n low, synchronous) empties the queue and output and restores the
// configuration registers: page_data_bytes 2048, bus_is_16_bit 0, three_row_cycles 1.
module nand_command_cycle_generator #(
  parameter int unsigned QueueDepth = nccg_pkg::NCCG_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  nccg_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output nccg_pkg::out_word_t out_word
);
  import nccg_pkg::*;

  req_t front_req;
  req_t head_req;
  logic q_full, q_empty, q_pop;

  assign in_stall = q_full;

  nccg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_word   (in_word),
    .req       (front_req)
  );

  nccg_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_valid),
    .push_req (front_req),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_req (head_req)
  );

  nccg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_avail (!q_empty),
    .req       (head_req),
    .req_pop   (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

/* rtl/nccg_front.sv */
module nccg_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  nccg_pkg::in_word_t in_word,
  output nccg_pkg::req_t    req
);
  import nccg_pkg::*;

  logic [15:0] page_bytes_r;
  logic        bus16_r;
  logic        three_rows_r;

  logic [15:0] col_base;
  logic [16:0] col_sum;
  logic        is_oob;
  logic [7:0]  cmd_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_bytes_r <= 16'd2048;
      bus16_r      <= 1'b0;
      three_rows_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PAGE_DATA_BYTES:  page_bytes_r <= cfg_data;
        CFG_BUS_IS_16_BIT:    bus16_r      <= cfg_data[0];
        CFG_THREE_ROW_CYCLES: three_rows_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    is_oob   = (in_word.opcode == CMD_READOOB);
    // an absent column counts as zero for an out-of-band read
    col_base = (is_oob && !in_word.column_present) ? 16'd0 : in_word.column_address;
    col_sum  = is_oob ? ({1'b0, col_base} + {1'b0, page_bytes_r}) : {1'b0, col_base};
    cmd_eff  = is_oob ? CMD_READ0 : in_word.opcode;

    req.cmd        = cmd_eff;
    req.col        = bus16_r ? col_sum[16:1] : col_sum[15:0];
    req.col_on     = in_word.column_present | is_oob;
    req.row        = in_word.row_address;
    req.row_on     = in_word.row_present;
    req.three_rows = three_rows_r;
    req.tail_on    = (cmd_eff == CMD_READ0) || (cmd_eff == CMD_RESET);
    req.tail_cmd   = (cmd_eff == CMD_RESET) ? CMD_READ_STATUS : CMD_READSTART;
  end

endmodule

/* rtl/nccg_queue.sv */
module nccg_queue #(
  parameter int unsigned Depth = nccg_pkg::NCCG_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  nccg_pkg::req_t push_req,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output nccg_pkg::req_t head_req
);
  import nccg_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  req_t            mem [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_push, do_pop;

  assign full     = (count_r == DepthCnt);
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_req = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_req;
    end
  end

endmodule

/* rtl/nccg_back.sv */
module nccg_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                req_avail,
  input  nccg_pkg::req_t      req,
  output logic                req_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output nccg_pkg::out_word_t out_word
);
  import nccg_pkg::*;

  localparam logic [3:0] ST_CMD      = 4'd0;
  localparam logic [3:0] ST_COL_LO   = 4'd1;
  localparam logic [3:0] ST_COL_HI   = 4'd2;
  localparam logic [3:0] ST_ROW0     = 4'd3;
  localparam logic [3:0] ST_ROW1     = 4'd4;
  localparam logic [3:0] ST_ROW2     = 4'd5;
  localparam logic [3:0] ST_IDLE     = 4'd6;
  localparam logic [3:0] ST_TAIL_CMD = 4'd7;
  localparam logic [3:0] ST_TAIL_IDL = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_word_t  out_word_r, out_word_nxt;
  logic       can_load, fire, done;
  logic [3:0] step_nxt;
  out_word_t  w;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign can_load  = !out_valid_r || !out_stall;
  assign fire      = can_load && req_avail;
  assign req_pop   = fire && done;

  always_comb begin
    w             = '0;
    w.chip_enable = 1'b1;
    step_nxt      = ST_CMD;
    done          = 1'b0;
    case (state_r)
      ST_CMD: begin
        w.bus_byte      = req.cmd;
        w.byte_driven   = 1'b1;
        w.command_latch = 1'b1;
        w.lines_changed = 1'b1;
        step_nxt = req.col_on ? ST_COL_LO : (req.row_on ? ST_ROW0 : ST_IDLE);
      end
      ST_COL_LO: begin
        w.bus_byte      = req.col[7:0];
        w.byte_driven   = 1'b1;
        w.address_latch = 1'b1;
        w.lines_changed = 1'b1;
        step_nxt        = ST_COL_HI;
      end
      ST_COL_HI: begin
        w.bus_byte      = req.col[15:8];
        w.byte_driven   = 1'b1;
        w.address_latch = 1'b1;
        step_nxt        = req.row_on ? ST_ROW0 : ST_IDLE;
      end
      ST_ROW0: begin
        w.bus_byte      = req.row[7:0];
        w.byte_driven   = 1'b1;
        w.address_latch = 1'b1;
        // first address word of the run flags the line change
        w.lines_changed = !req.col_on;
        step_nxt        = ST_ROW1;
      end
      ST_ROW1: begin
        w.bus_byte      = req.row[15:8];
        w.byte_driven   = 1'b1;
        w.address_latch = 1'b1;
        step_nxt        = req.three_rows ? ST_ROW2 : ST_IDLE;
      end
      ST_ROW2: begin
        w.bus_byte      = req.row[23:16];
        w.byte_driven   = 1'b1;
        w.address_latch = 1'b1;
        step_nxt        = ST_IDLE;
      end
      ST_IDLE: begin
        w.lines_changed = 1'b1;
        w.last_cycle    = !req.tail_on;
        done            = !req.tail_on;
        step_nxt        = req.tail_on ? ST_TAIL_CMD : ST_CMD;
      end
      ST_TAIL_CMD: begin
        w.bus_byte      = req.tail_cmd;
        w.byte_driven   = 1'b1;
        w.command_latch = 1'b1;
        w.lines_changed = 1'b1;
        step_nxt        = ST_TAIL_IDL;
      end
      ST_TAIL_IDL: begin
        w.lines_changed = 1'b1;
        w.last_cycle    = 1'b1;
        done            = 1'b1;
        step_nxt        = ST_CMD;
      end
      default: begin
        step_nxt = ST_CMD;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    if (fire) begin
      state_nxt     = step_nxt;
      out_valid_nxt = 1'b1;
      out_word_nxt  = w;
    end else if (can_load) begin
      // output taken and nothing queued: drop valid
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CMD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

endmodule
